### design/nnis_pkg.sv
// shared constants and types for the nearest neighbor image scaler
package nnis_pkg;

    localparam int DEF_MAX_DST_WIDTH  = 512;
    localparam int DEF_MAX_DST_HEIGHT = 512;

    localparam int SRC_W   = 10;
    localparam int SCALE_W = 12;
    localparam int CC_W    = 2;
    localparam int SZ_W    = 14;
    localparam int LD_W    = 9;
    localparam int UP_W    = 5;
    localparam int DN_W    = 4;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int POS_W   = 9;
    localparam int CFG_IDX_W = 4;

    localparam logic [SRC_W-1:0] SRC_MAX = SRC_W'(512);

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q8      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = CFG_IDX_W'(3);

    typedef struct packed {
        logic [SRC_W-1:0]   sw;
        logic [SRC_W-1:0]   sh;
        logic [SZ_W-1:0]    dw;
        logic [SZ_W-1:0]    dh;
        logic [SCALE_W-1:0] scale;
        logic [UP_W-1:0]    up;
        logic [DN_W-1:0]    dn;
        logic [CC_W-1:0]    cc;
    } t_geom;

endpackage

### design/nnis_if.sv
// valid/ready channels of the scaler: input items, result items, register writes
interface nnis_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
    modport source (output valid, kind, in_ch0, in_ch1, in_ch2, input ready);
    modport sink   (input valid, kind, in_ch0, in_ch1, in_ch2, output ready);
endinterface

interface nnis_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [8:0] target_col;
    logic [8:0] target_row;
    logic       frame_end;
    modport source (output valid, out_ch0, out_ch1, out_ch2, target_col, target_row,
                    frame_end, input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_ch2, target_col, target_row,
                    frame_end, output ready);
endinterface

interface nnis_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/nnis_cfg.sv
// configuration registers and derived target geometry
module nnis_cfg #(
    parameter int MAX_DST_WIDTH  = nnis_pkg::DEF_MAX_DST_WIDTH,
    parameter int MAX_DST_HEIGHT = nnis_pkg::DEF_MAX_DST_HEIGHT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nnis_cfg_if.sink        i_cfg,
    output nnis_pkg::t_geom o_geom
);
    import nnis_pkg::*;

    logic [SRC_W-1:0]   r_src_width;
    logic [SRC_W-1:0]   r_src_height;
    logic [SCALE_W-1:0] r_scale_q8;
    logic [CC_W-1:0]    r_channel_count;
    logic [SRC_W-1:0]   w_sw;
    logic [SRC_W-1:0]   w_sh;
    logic [21:0]        w_prod_w;
    logic [21:0]        w_prod_h;
    logic [SZ_W-1:0]    w_dw_raw;
    logic [SZ_W-1:0]    w_dh_raw;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width     <= SRC_W'(1);
            r_src_height    <= SRC_W'(1);
            r_scale_q8      <= SCALE_W'(256);
            r_channel_count <= CC_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SRC_WIDTH:     r_src_width     <= i_cfg.data[SRC_W-1:0];
                CFG_SRC_HEIGHT:    r_src_height    <= i_cfg.data[SRC_W-1:0];
                CFG_SCALE_Q8:      r_scale_q8      <= i_cfg.data[SCALE_W-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[CC_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, anything above the source limit is clipped
    assign w_sw = (r_src_width == '0) ? SRC_W'(1) :
                  (r_src_width > SRC_MAX) ? SRC_MAX : r_src_width;
    assign w_sh = (r_src_height == '0) ? SRC_W'(1) :
                  (r_src_height > SRC_MAX) ? SRC_MAX : r_src_height;

    assign w_prod_w = 22'(w_sw) * 22'(r_scale_q8);
    assign w_prod_h = 22'(w_sh) * 22'(r_scale_q8);
    assign w_dw_raw = w_prod_w[21:8];
    assign w_dh_raw = w_prod_h[21:8];

    always_comb begin
        o_geom.sw    = w_sw;
        o_geom.sh    = w_sh;
        o_geom.dw    = (w_dw_raw > SZ_W'(MAX_DST_WIDTH))  ? SZ_W'(MAX_DST_WIDTH)  : w_dw_raw;
        o_geom.dh    = (w_dh_raw > SZ_W'(MAX_DST_HEIGHT)) ? SZ_W'(MAX_DST_HEIGHT) : w_dh_raw;
        o_geom.scale = r_scale_q8;
        o_geom.up    = UP_W'((13'(r_scale_q8) + 13'd255) >> 8);
        o_geom.dn    = r_scale_q8[11:8];
        o_geom.cc    = (r_channel_count == '0) ? CC_W'(1) : r_channel_count;
    end

endmodule

### design/nearest_neighbor_image_scaler_core.sv
// Nearest neighbor image scaler: source pixels scatter into a target frame buffer,
// requests read target pixels back in raster order, filling holes from the nearest
// colored neighbor.
// Channels: i_in carries beats of kind 0 (load next source pixel) or kind 1
// (request next target pixel); o_out carries one beat per request unless the target
// frame is empty; i_cfg writes the four geometry registers and is always ready.
// A load writes its scattered pixel if it falls inside the target frame. A request
// reads its target entry in S_REQ and checks the colored mark in S_CTRW; a colored
// one goes to S_DONE, an uncolored one walks its search window in S_SCAN, one
// memory read per cycle, then settles in S_DRAIN. The single frame buffer read
// port sets that rate. S_DONE fills the output register once it is free.
// After reset the block clears the colored marks, one buffer entry a cycle, over all
// MAX_DST_WIDTH * MAX_DST_HEIGHT entries; i_in.ready stays low during that pass.
// The result waits in an output register; the next beat is accepted meanwhile,
// and a request that finishes while the receiver stalls waits until the
// register frees.
module nearest_neighbor_image_scaler_core #(
    parameter int MAX_DST_WIDTH  = nnis_pkg::DEF_MAX_DST_WIDTH,
    parameter int MAX_DST_HEIGHT = nnis_pkg::DEF_MAX_DST_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nnis_in_if.sink     i_in,
    nnis_out_if.source  o_out,
    nnis_cfg_if.sink    i_cfg
);
    import nnis_pkg::*;

    localparam int XW = $clog2(MAX_DST_WIDTH);
    localparam int YW = $clog2(MAX_DST_HEIGHT);

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_LOAD  = 8'b0000_0100,
        S_REQ   = 8'b0000_1000,
        S_CTRW  = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_geom w_geom;

    t_state r_state;
    logic [XW-1:0]    r_sx, r_xmin, r_xmax, r_emit_col;
    logic [YW-1:0]    r_sy, r_ymin, r_ymax, r_emit_row;
    logic [LD_W-1:0]  r_load_row, r_load_col;
    logic             r_kind;
    logic [PIX_W-1:0] r_in_pix;
    logic [PIX_W:0]   r_mem [MAX_DST_HEIGHT][MAX_DST_WIDTH];
    logic [PIX_W:0]   r_rdata;
    logic             r_pv;
    logic [9:0]       r_pd, r_best;
    logic             r_found;
    logic             r_chk;
    logic [PIX_W-1:0] r_val;
    logic             r_ov;
    logic [CH_W-1:0]  r_o_ch0, r_o_ch1, r_o_ch2;
    logic [POS_W-1:0] r_o_col, r_o_row;
    logic             r_o_end;

    logic [YW-1:0]    w_rd_y;
    logic [XW-1:0]    w_rd_x;
    logic             w_we;
    logic [YW-1:0]    w_wr_y;
    logic [XW-1:0]    w_wr_x;
    logic [PIX_W:0]   w_wr_d;
    logic             w_pos_bad;
    logic [XW-1:0]    w_ex;
    logic [YW-1:0]    w_ey;
    logic             w_ld_bad;
    logic [LD_W-1:0]  w_lr, w_lc;
    logic [20:0]      w_tr_p, w_tc_p;
    logic [12:0]      w_tr, w_tc;
    logic             w_ld_in;
    logic [SZ_W-1:0]  w_xs, w_ys, w_xhi, w_yhi;
    logic [XW-1:0]    w_ddx_f;
    logic [YW-1:0]    w_ddy_f;
    logic [UP_W-1:0]  w_ddx, w_ddy;
    logic [9:0]       w_dist;
    logic             w_out_free;
    logic [PIX_W-1:0] w_pix;

    nnis_cfg #(
        .MAX_DST_WIDTH  (MAX_DST_WIDTH),
        .MAX_DST_HEIGHT (MAX_DST_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_geom  (w_geom)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_free = !r_ov || o_out.ready;

    // emit position restarts when the geometry shrank under it
    assign w_pos_bad = (SZ_W'(r_emit_col) >= w_geom.dw) || (SZ_W'(r_emit_row) >= w_geom.dh);
    assign w_ex = w_pos_bad ? '0 : r_emit_col;
    assign w_ey = w_pos_bad ? '0 : r_emit_row;

    // scatter position of the pending load
    assign w_ld_bad = (SRC_W'(r_load_row) >= w_geom.sh) || (SRC_W'(r_load_col) >= w_geom.sw);
    assign w_lr   = w_ld_bad ? '0 : r_load_row;
    assign w_lc   = w_ld_bad ? '0 : r_load_col;
    assign w_tr_p = 21'(w_lr) * 21'(w_geom.scale);
    assign w_tc_p = 21'(w_lc) * 21'(w_geom.scale);
    assign w_tr   = w_tr_p[20:8];
    assign w_tc   = w_tc_p[20:8];
    assign w_ld_in = (SZ_W'(w_tr) < w_geom.dh) && (SZ_W'(w_tc) < w_geom.dw);

    // window bounds around the current emit position
    assign w_xs  = SZ_W'(r_emit_col);
    assign w_ys  = SZ_W'(r_emit_row);
    assign w_xhi = w_xs + SZ_W'(w_geom.dn);
    assign w_yhi = w_ys + SZ_W'(w_geom.dn);

    // squared distance of the entry being read
    assign w_ddx_f = (r_sx > r_emit_col) ? r_sx - r_emit_col : r_emit_col - r_sx;
    assign w_ddy_f = (r_sy > r_emit_row) ? r_sy - r_emit_row : r_emit_row - r_sy;
    assign w_ddx   = UP_W'(w_ddx_f);
    assign w_ddy   = UP_W'(w_ddy_f);
    assign w_dist  = 10'(w_ddx) * 10'(w_ddx) + 10'(w_ddy) * 10'(w_ddy);

    always_comb begin
        w_rd_y = r_emit_row;
        w_rd_x = r_emit_col;
        w_we   = 1'b0;
        w_wr_y = r_sy;
        w_wr_x = r_sx;
        w_wr_d = '0;
        case (r_state)
            S_REQ: begin
                w_rd_y = w_ey;
                w_rd_x = w_ex;
            end
            S_SCAN: begin
                w_rd_y = r_sy;
                w_rd_x = r_sx;
            end
            S_DRAIN: begin
                w_rd_y = '0;
                w_rd_x = '0;
            end
            S_CLR: begin
                w_we = 1'b1;
            end
            S_LOAD: begin
                w_we   = !r_kind && w_ld_in;
                w_wr_y = YW'(w_tr);
                w_wr_x = XW'(w_tc);
                w_wr_d = {1'b1, r_in_pix};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_y][w_wr_x] <= w_wr_d;
        end
        r_rdata <= r_mem[w_rd_y][w_rd_x];
    end

    // final pixel: nearest hit, else target origin if colored, else zero
    assign w_pix = r_found ? r_val : (r_rdata[PIX_W] ? r_rdata[PIX_W-1:0] : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_sx       <= '0;
            r_sy       <= '0;
            r_load_row <= '0;
            r_load_col <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
            r_pv       <= 1'b0;
            r_found    <= 1'b0;
            r_chk      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            // a new beat loaded in the same cycle keeps the register full
            if (r_ov && o_out.ready && !(r_state == S_DONE && !r_chk)) begin
                r_ov <= 1'b0;
            end

            // compare returned scan reads
            if (r_pv && r_rdata[PIX_W] && (!r_found || r_pd < r_best)) begin
                r_found <= 1'b1;
                r_best  <= r_pd;
                r_val   <= r_rdata[PIX_W-1:0];
            end

            unique case (r_state)
                S_CLR: begin
                    if (r_sx == XW'(MAX_DST_WIDTH - 1)) begin
                        r_sx <= '0;
                        if (r_sy == YW'(MAX_DST_HEIGHT - 1)) begin
                            r_sy    <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_sy <= r_sy + YW'(1);
                        end
                    end else begin
                        r_sx <= r_sx + XW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind   <= i_in.kind;
                        r_in_pix <= {i_in.in_ch2, i_in.in_ch1, i_in.in_ch0};
                        r_state  <= i_in.kind ? S_REQ : S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (SRC_W'(w_lc) + SRC_W'(1) >= w_geom.sw) begin
                        r_load_col <= '0;
                        r_load_row <= (SRC_W'(w_lr) + SRC_W'(1) >= w_geom.sh) ? '0 :
                                      w_lr + LD_W'(1);
                    end else begin
                        r_load_row <= w_lr;
                        r_load_col <= w_lc + LD_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_REQ: begin
                    if (w_geom.dw == '0 || w_geom.dh == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_emit_col <= w_ex;
                        r_emit_row <= w_ey;
                        r_state    <= S_CTRW;
                    end
                end
                S_CTRW: begin
                    r_found <= r_rdata[PIX_W];
                    if (r_rdata[PIX_W]) begin
                        r_val   <= r_rdata[PIX_W-1:0];
                        r_state <= S_DONE;
                    end else begin
                        r_xmin  <= (w_xs > SZ_W'(w_geom.up)) ? XW'(w_xs - SZ_W'(w_geom.up)) : '0;
                        r_ymin  <= (w_ys > SZ_W'(w_geom.up)) ? YW'(w_ys - SZ_W'(w_geom.up)) : '0;
                        r_xmax  <= (w_xhi > w_geom.dw - SZ_W'(1)) ? XW'(w_geom.dw - SZ_W'(1)) :
                                   XW'(w_xhi);
                        r_ymax  <= (w_yhi > w_geom.dh - SZ_W'(1)) ? YW'(w_geom.dh - SZ_W'(1)) :
                                   YW'(w_yhi);
                        r_sx    <= (w_xs > SZ_W'(w_geom.up)) ? XW'(w_xs - SZ_W'(w_geom.up)) : '0;
                        r_sy    <= (w_ys > SZ_W'(w_geom.up)) ? YW'(w_ys - SZ_W'(w_geom.up)) : '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pv <= 1'b1;
                    r_pd <= w_dist;
                    if (r_sx == r_xmax) begin
                        r_sx <= r_xmin;
                        r_sy <= r_sy + YW'(1);
                        if (r_sy == r_ymax) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_sx <= r_sx + XW'(1);
                    end
                end
                S_DRAIN: begin
                    // last scan read settles here while the origin is read
                    r_pv    <= 1'b0;
                    r_chk   <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_chk) begin
                        r_chk <= 1'b0;
                        r_val <= w_pix;
                    end else if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_o_ch0 <= r_val[7:0];
                        r_o_ch1 <= (w_geom.cc > CC_W'(1)) ? r_val[15:8] : '0;
                        r_o_ch2 <= (w_geom.cc > CC_W'(2)) ? r_val[23:16] : '0;
                        r_o_col <= POS_W'(r_emit_col);
                        r_o_row <= POS_W'(r_emit_row);
                        r_o_end <= (SZ_W'(r_emit_row) == w_geom.dh - SZ_W'(1)) &&
                                   (SZ_W'(r_emit_col) == w_geom.dw - SZ_W'(1));
                        if (SZ_W'(r_emit_col) + SZ_W'(1) >= w_geom.dw) begin
                            r_emit_col <= '0;
                            r_emit_row <= (SZ_W'(r_emit_row) + SZ_W'(1) >= w_geom.dh) ? '0 :
                                          r_emit_row + YW'(1);
                        end else begin
                            r_emit_col <= r_emit_col + XW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_ch0    = r_o_ch0;
    assign o_out.out_ch1    = r_o_ch1;
    assign o_out.out_ch2    = r_o_ch2;
    assign o_out.target_col = r_o_col;
    assign o_out.target_row = r_o_row;
    assign o_out.frame_end  = r_o_end;

endmodule

### design/nnis_checker.sv
// port-level checks for the scaler, bound to the top level
module nnis_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_cfg_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_ch0,
    input logic [8:0] i_out_col,
    input logic [8:0] i_out_row
);

    // clear pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

    // a new result only appears after the block was busy with its request
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a request in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_ch0) && $stable(i_out_col) && $stable(i_out_row))
        else $error("stalled result beat changed");

endmodule

bind nearest_neighbor_image_scaler_core nnis_checker u_nnis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ch0   (o_out.out_ch0),
    .i_out_col   (o_out.target_col),
    .i_out_row   (o_out.target_row)
);
